// File: src/trc_pkg.sv
// Types, constants and helper functions for the transfer range coalescer.
// Shared by trc_plan and transfer_range_coalescer; depends on nothing else.
package trc_pkg;

    // Field widths of offsets and descriptor counts.
    localparam int OFFSET_BITS = 48;
    localparam int COUNT_BITS  = 32;

    // Most records that one descriptor can cause, and the width of a record count.
    localparam int REC_MAX     = 4;
    localparam int REC_IDX_W   = $clog2(REC_MAX);
    localparam int REC_CNT_W   = $clog2(REC_MAX + 1);

    // Configuration port: 64-bit data, registers at byte addresses 0 and 8.
    localparam int PDATA_BITS  = 64;
    localparam int PADDR_BITS  = 4;

    localparam logic [OFFSET_BITS-1:0] OFF_ONE  = OFFSET_BITS'(1);
    localparam logic [OFFSET_BITS-1:0] OFF_ZERO = '0;
    localparam logic [COUNT_BITS-1:0]  CNT_ONE  = COUNT_BITS'(1);
    localparam logic [COUNT_BITS-1:0]  CNT_ZERO = '0;

    localparam logic [OFFSET_BITS-1:0] CHUNK_BYTES_RST = OFFSET_BITS'(1048576);

    // Register indexes, taken from the address bit above the word offset.
    localparam logic REG_PLAN_MODE   = 1'b0;
    localparam logic REG_CHUNK_BYTES = 1'b1;

    // Record kinds.
    localparam logic KIND_DESC = 1'b0;
    localparam logic KIND_SEG  = 1'b1;

    typedef enum logic [1:0] {
        PLAN_CHUNK    = 2'd0,
        PLAN_SPAN     = 2'd1,
        PLAN_SINGLE   = 2'd2,
        PLAN_COALESCE = 2'd3
    } t_plan_mode;

    // One copy descriptor on the input channel.
    typedef struct packed {
        logic [OFFSET_BITS-1:0] source_offset;
        logic [OFFSET_BITS-1:0] dest_offset;
        logic [OFFSET_BITS-1:0] length;
        logic                   batch_last;
    } t_in_word;

    // One record on the output channel.
    typedef struct packed {
        logic                   record_kind;
        logic [OFFSET_BITS-1:0] word_a;
        logic [OFFSET_BITS-1:0] word_b;
        logic [OFFSET_BITS-1:0] word_c;
        logic [COUNT_BITS-1:0]  descriptor_count;
        logic                   run_last;
        logic                   batch_done;
    } t_out_word;

    typedef t_out_word [REC_MAX-1:0] t_rec_list;

    // Open segment and the descriptor held back in coalescing mode.
    typedef struct packed {
        logic                   seg_open;
        logic [OFFSET_BITS-1:0] seg_start;
        logic [OFFSET_BITS-1:0] seg_end;
        logic [OFFSET_BITS-1:0] seg_bytes;
        logic [COUNT_BITS-1:0]  seg_desc_count;
        logic                   pend_valid;
        logic [OFFSET_BITS-1:0] pend_source;
        logic [OFFSET_BITS-1:0] pend_dest;
        logic [OFFSET_BITS-1:0] pend_length;
    } t_seg_state;

    // Builds a record with both end markers clear.
    function automatic t_out_word mk_rec(
        input logic                   kind,
        input logic [OFFSET_BITS-1:0] a,
        input logic [OFFSET_BITS-1:0] b,
        input logic [OFFSET_BITS-1:0] c,
        input logic [COUNT_BITS-1:0]  cnt
    );
        t_out_word rec;
        rec.record_kind      = kind;
        rec.word_a           = a;
        rec.word_b           = b;
        rec.word_c           = c;
        rec.descriptor_count = cnt;
        rec.run_last         = 1'b0;
        rec.batch_done       = 1'b0;
        return rec;
    endfunction

    // Byte total that sticks at all ones once it overflows.
    function automatic logic [OFFSET_BITS-1:0] sat_bytes(
        input logic [OFFSET_BITS-1:0] a,
        input logic [OFFSET_BITS-1:0] b
    );
        logic [OFFSET_BITS:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        return sum[OFFSET_BITS] ? '1 : sum[OFFSET_BITS-1:0];
    endfunction

    // Descriptor count increment that sticks at all ones.
    function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] a);
        return (a == '1) ? a : a + CNT_ONE;
    endfunction

endpackage

// File: src/trc_plan.sv
// Planning logic: from one descriptor, the mode and the segment state it
// builds the list of records and the next state. Depends on trc_pkg.
module trc_plan (
    input  trc_pkg::t_plan_mode             i_mode,
    input  logic [trc_pkg::OFFSET_BITS-1:0] i_chunk_bytes,
    input  trc_pkg::t_seg_state             i_state,
    input  trc_pkg::t_in_word               i_item,
    output trc_pkg::t_seg_state             o_state,
    output trc_pkg::t_rec_list              o_recs,
    output logic [trc_pkg::REC_CNT_W-1:0]   o_count
);
    import trc_pkg::*;

    t_seg_state             st;
    t_rec_list              recs;
    logic [REC_CNT_W-1:0]   n;
    logic [REC_CNT_W-1:0]   n_last;
    logic [OFFSET_BITS-1:0] src;
    logic [OFFSET_BITS-1:0] dst;
    logic [OFFSET_BITS-1:0] len;
    logic [OFFSET_BITS-1:0] end_off;
    logic [OFFSET_BITS-1:0] seg_next;
    logic [OFFSET_BITS-1:0] pend_next;
    logic [OFFSET_BITS:0]   merge_sum;
    logic                   contig;
    logic                   merge;

    // Offsets and the contiguity tests, all modulo the offset width.
    always_comb begin
        src       = i_item.source_offset;
        dst       = i_item.dest_offset;
        len       = i_item.length;
        end_off   = src + len - OFF_ONE;
        seg_next  = i_state.seg_end + OFF_ONE;
        pend_next = i_state.pend_dest + i_state.pend_length;
        merge_sum = {1'b0, i_state.pend_length} + {1'b0, len};
        contig    = i_state.seg_open && (seg_next == src);
        merge     = i_state.pend_valid && (pend_next == dst) && !merge_sum[OFFSET_BITS];
    end

    // Records in emission order; n counts the slots filled so far.
    always_comb begin
        st   = i_state;
        recs = '0;
        n    = '0;
        case (i_mode)
            PLAN_CHUNK, PLAN_SPAN: begin
                if (st.pend_valid) begin
                    recs[n[REC_IDX_W-1:0]] = mk_rec(KIND_DESC, st.pend_source, st.pend_dest,
                                                    st.pend_length, CNT_ZERO);
                    n = n + 1'b1;
                end
                st.pend_valid = 1'b0;
                recs[n[REC_IDX_W-1:0]] = mk_rec(KIND_DESC, src, dst, len, CNT_ZERO);
                n = n + 1'b1;
                if (!st.seg_open) begin
                    st.seg_open       = 1'b1;
                    st.seg_start      = src;
                    st.seg_end        = end_off;
                    st.seg_bytes      = len;
                    st.seg_desc_count = CNT_ONE;
                end else begin
                    st.seg_end        = end_off;
                    st.seg_bytes      = sat_bytes(st.seg_bytes, len);
                    st.seg_desc_count = sat_inc(st.seg_desc_count);
                end
                if (i_item.batch_last) begin
                    if (i_mode == PLAN_CHUNK) begin
                        recs[n[REC_IDX_W-1:0]] = mk_rec(KIND_SEG, OFF_ZERO,
                                                        i_chunk_bytes - OFF_ONE,
                                                        st.seg_bytes, st.seg_desc_count);
                    end else begin
                        recs[n[REC_IDX_W-1:0]] = mk_rec(KIND_SEG, st.seg_start, st.seg_end,
                                                        st.seg_bytes, st.seg_desc_count);
                    end
                    n = n + 1'b1;
                    st.seg_open = 1'b0;
                end
            end
            PLAN_SINGLE: begin
                if (st.pend_valid) begin
                    recs[n[REC_IDX_W-1:0]] = mk_rec(KIND_DESC, st.pend_source, st.pend_dest,
                                                    st.pend_length, CNT_ZERO);
                    n = n + 1'b1;
                end
                st.pend_valid = 1'b0;
                if (st.seg_open) begin
                    recs[n[REC_IDX_W-1:0]] = mk_rec(KIND_SEG, st.seg_start, st.seg_end,
                                                    st.seg_bytes, st.seg_desc_count);
                    n = n + 1'b1;
                end
                st.seg_open = 1'b0;
                recs[n[REC_IDX_W-1:0]] = mk_rec(KIND_DESC, src, dst, len, CNT_ZERO);
                n = n + 1'b1;
                recs[n[REC_IDX_W-1:0]] = mk_rec(KIND_SEG, src, end_off, len, CNT_ONE);
                n = n + 1'b1;
            end
            PLAN_COALESCE: begin
                if (contig) begin
                    // Extends the open segment; the held descriptor grows or is replaced.
                    st.seg_end   = end_off;
                    st.seg_bytes = sat_bytes(st.seg_bytes, len);
                    if (merge) begin
                        st.pend_length = merge_sum[OFFSET_BITS-1:0];
                    end else begin
                        if (st.pend_valid) begin
                            recs[n[REC_IDX_W-1:0]] = mk_rec(KIND_DESC, st.pend_source,
                                                            st.pend_dest, st.pend_length,
                                                            CNT_ZERO);
                            n = n + 1'b1;
                        end
                        st.pend_valid     = 1'b1;
                        st.pend_source    = src;
                        st.pend_dest      = dst;
                        st.pend_length    = len;
                        st.seg_desc_count = sat_inc(st.seg_desc_count);
                    end
                end else begin
                    // A gap in the source closes the segment and opens a new one.
                    if (st.pend_valid) begin
                        recs[n[REC_IDX_W-1:0]] = mk_rec(KIND_DESC, st.pend_source,
                                                        st.pend_dest, st.pend_length,
                                                        CNT_ZERO);
                        n = n + 1'b1;
                    end
                    if (st.seg_open) begin
                        recs[n[REC_IDX_W-1:0]] = mk_rec(KIND_SEG, st.seg_start, st.seg_end,
                                                        st.seg_bytes, st.seg_desc_count);
                        n = n + 1'b1;
                    end
                    st.seg_open       = 1'b1;
                    st.seg_start      = src;
                    st.seg_end        = end_off;
                    st.seg_bytes      = len;
                    st.seg_desc_count = CNT_ONE;
                    st.pend_valid     = 1'b1;
                    st.pend_source    = src;
                    st.pend_dest      = dst;
                    st.pend_length    = len;
                end
                if (i_item.batch_last) begin
                    if (st.pend_valid) begin
                        recs[n[REC_IDX_W-1:0]] = mk_rec(KIND_DESC, st.pend_source,
                                                        st.pend_dest, st.pend_length,
                                                        CNT_ZERO);
                        n = n + 1'b1;
                    end
                    st.pend_valid = 1'b0;
                    if (st.seg_open) begin
                        recs[n[REC_IDX_W-1:0]] = mk_rec(KIND_SEG, st.seg_start, st.seg_end,
                                                        st.seg_bytes, st.seg_desc_count);
                        n = n + 1'b1;
                    end
                    st.seg_open = 1'b0;
                end
            end
            default: begin
                st = i_state;
            end
        endcase

        // Mark the final record of this descriptor, and of the batch.
        n_last = n - 1'b1;
        if (n != '0) begin
            recs[n_last[REC_IDX_W-1:0]].run_last   = 1'b1;
            recs[n_last[REC_IDX_W-1:0]].batch_done = i_item.batch_last;
        end
    end

    assign o_state = st;
    assign o_recs  = recs;
    assign o_count = n;

endmodule

// File: src/transfer_range_coalescer.sv
// Transfer range coalescer: a descriptor word is registered, planned combinationally into
// up to four records, and the records leave one word per cycle, unless the output stalls,
// from a record buffer. A word passes the input register and the record buffer before
// its first record is valid. A new word can be planned as the last record of the word
// before it leaves; the single output port limits the input rate.
// Reset (synchronous, active low) empties the pipeline, closes any open segment and
// restores plan_mode to coalescing and chunk_bytes to 1048576.
module transfer_range_coalescer (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // Descriptor input channel
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  trc_pkg::t_in_word               i_in_word,
    // Record output channel
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output trc_pkg::t_out_word              o_out_word,
    // Configuration port
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [trc_pkg::PADDR_BITS-1:0]  paddr,
    input  logic [trc_pkg::PDATA_BITS-1:0]  pwdata,
    output logic [trc_pkg::PDATA_BITS-1:0]  prdata,
    output logic                            pready
);
    import trc_pkg::*;

    t_plan_mode             r_plan_mode;
    logic [OFFSET_BITS-1:0] r_chunk_bytes;

    logic                   r_in_valid;
    t_in_word               r_in_word;

    t_seg_state             r_state;
    t_seg_state             n_state;

    t_rec_list              r_q;
    t_rec_list              n_recs;
    logic [REC_CNT_W-1:0]   n_count;
    logic [REC_CNT_W-1:0]   r_q_left;
    logic [REC_IDX_W-1:0]   r_q_idx;

    logic                   in_take;
    logic                   out_pop;
    logic                   load;
    logic                   cfg_write;
    logic                   reg_sel;

    // Configuration registers.
    assign pready    = 1'b1;
    assign reg_sel   = paddr[PADDR_BITS-1];
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_plan_mode   <= PLAN_COALESCE;
            r_chunk_bytes <= CHUNK_BYTES_RST;
        end else if (cfg_write) begin
            case (reg_sel)
                REG_PLAN_MODE:   r_plan_mode   <= t_plan_mode'(pwdata[1:0]);
                REG_CHUNK_BYTES: r_chunk_bytes <= pwdata[OFFSET_BITS-1:0];
                default:         r_plan_mode   <= r_plan_mode;
            endcase
        end
    end

    always_comb begin
        case (reg_sel)
            REG_PLAN_MODE:   prdata = PDATA_BITS'(r_plan_mode);
            REG_CHUNK_BYTES: prdata = PDATA_BITS'(r_chunk_bytes);
            default:         prdata = '0;
        endcase
    end

    // Handshakes: a word is planned once the record buffer is empty or drains this cycle.
    assign out_pop    = o_out_valid && !i_out_stall;
    assign load       = r_in_valid && ((r_q_left == '0) ||
                                       ((r_q_left == REC_CNT_W'(1)) && out_pop));
    assign o_in_stall = r_in_valid && !load;
    assign in_take    = i_in_valid && !o_in_stall;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (load) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_word <= i_in_word;
        end
    end

    // Planning logic for the registered word.
    trc_plan u_plan (
        .i_mode        (r_plan_mode),
        .i_chunk_bytes (r_chunk_bytes),
        .i_state       (r_state),
        .i_item        (r_in_word),
        .o_state       (n_state),
        .o_recs        (n_recs),
        .o_count       (n_count)
    );

    // Segment state advances when a word is planned.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (load) begin
            r_state <= n_state;
        end
    end

    // Record buffer: loaded whole, then read out one record per cycle while the output is not stalled.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q_left <= '0;
            r_q_idx  <= '0;
        end else if (load) begin
            r_q_left <= n_count;
            r_q_idx  <= '0;
        end else if (out_pop) begin
            r_q_left <= r_q_left - 1'b1;
            r_q_idx  <= r_q_idx + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_q <= n_recs;
        end
    end

    assign o_out_valid = (r_q_left != '0);
    assign o_out_word  = r_q[r_q_idx];

`ifndef SYNTHESIS
    // A held descriptor always belongs to an open segment.
    a_pend_in_seg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.pend_valid |-> r_state.seg_open)
        else $error("held descriptor without an open segment");

    // A segment record covers at least one descriptor; a descriptor record carries none.
    a_seg_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((o_out_word.record_kind == KIND_SEG) ==
                         (o_out_word.descriptor_count != CNT_ZERO)))
        else $error("segment record count does not match record kind");

    // The end of a batch is also the end of the word's records.
    a_done_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_word.batch_done) |-> o_out_word.run_last)
        else $error("batch end flagged on a record that is not the last");

    // The last record of a word is the one the buffer holds last.
    a_last_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_word.run_last == (r_q_left == REC_CNT_W'(1))))
        else $error("run end flag out of place in the record buffer");
`endif

endmodule
